// File: rtl/lcrma_pkg.sv
// ----------------------------------------------------------------------------
// lcrma_pkg
// Types, codes and Q24 threshold tables for the LCR meter autorange core.
// ----------------------------------------------------------------------------
package lcrma_pkg;

	localparam int FRAC_BITS = 16;
	localparam int SHIFT_Q   = 24 - FRAC_BITS;
	localparam int MEAS_W    = 40;
	localparam int IMP_W     = 39;
	localparam int QW        = MEAS_W + SHIFT_Q;
	localparam int TBL_W     = 54;
	localparam int CMPW      = (QW > TBL_W) ? QW : TBL_W;

	typedef logic [CMPW-1:0] qval_t;

	typedef logic [1:0] op_t;
	localparam op_t OP_CLASSIFY = 2'd0;
	localparam op_t OP_RANGE    = 2'd1;
	localparam op_t OP_APPLY    = 2'd2;

	typedef logic [1:0] ptype_t;
	localparam ptype_t PT_UNKNOWN = 2'd0;
	localparam ptype_t PT_RES     = 2'd1;
	localparam ptype_t PT_IND     = 2'd2;
	localparam ptype_t PT_CAP     = 2'd3;

	typedef logic [1:0] freq_t;
	localparam freq_t FREQ_122  = 2'd0;
	localparam freq_t FREQ_977  = 2'd1;
	localparam freq_t FREQ_15K6 = 2'd2;
	localparam freq_t FREQ_93K7 = 2'd3;

	typedef logic [2:0] sense_t;
	localparam sense_t SENSE_100R = 3'd0;
	localparam sense_t SENSE_1K   = 3'd1;
	localparam sense_t SENSE_10K  = 3'd2;
	localparam sense_t SENSE_100K = 3'd3;
	localparam sense_t SENSE_10R  = 3'd4;

	typedef logic [1:0] gain_t;
	localparam gain_t GAIN_X2   = 2'd0;
	localparam gain_t GAIN_X5   = 2'd1;
	localparam gain_t GAIN_X13  = 2'd2;
	localparam gain_t GAIN_X34  = 2'd3;

	typedef logic [2:0] mask_t;
	localparam mask_t PEND_FREQ  = 3'b001;
	localparam mask_t PEND_SG    = 3'b110;
	localparam mask_t PEND_ALL   = 3'b111;

	typedef struct packed {
		freq_t  freq;
		sense_t sense;
		gain_t  gain;
		ptype_t ptype;
		mask_t  pending;
	} state_t;

	localparam state_t STATE_RESET = '{
		freq: FREQ_977, sense: SENSE_1K, gain: GAIN_X2, ptype: PT_UNKNOWN,
		pending: PEND_ALL
	};

	// |X| bounds per frequency for L = 0.5, 0.05, 5e-3, 5e-4, 5e-5, 5e-6 H
	function automatic qval_t ind_bound(input freq_t f, input logic [2:0] i);
		logic [63:0] v;
		v = 64'd0;
		case ({f, i})
			{FREQ_122, 3'd0}:  v = 64'd6433981755;
			{FREQ_122, 3'd1}:  v = 64'd643398176;
			{FREQ_122, 3'd2}:  v = 64'd64339818;
			{FREQ_122, 3'd3}:  v = 64'd6433982;
			{FREQ_122, 3'd4}:  v = 64'd643399;
			{FREQ_122, 3'd5}:  v = 64'd64340;
			{FREQ_977, 3'd0}:  v = 64'd51471854037;
			{FREQ_977, 3'd1}:  v = 64'd5147185404;
			{FREQ_977, 3'd2}:  v = 64'd514718541;
			{FREQ_977, 3'd3}:  v = 64'd51471855;
			{FREQ_977, 3'd4}:  v = 64'd5147186;
			{FREQ_977, 3'd5}:  v = 64'd514719;
			{FREQ_15K6, 3'd0}: v = 64'd823549664583;
			{FREQ_15K6, 3'd1}: v = 64'd82354966459;
			{FREQ_15K6, 3'd2}: v = 64'd8235496646;
			{FREQ_15K6, 3'd3}: v = 64'd823549665;
			{FREQ_15K6, 3'd4}: v = 64'd82354967;
			{FREQ_15K6, 3'd5}: v = 64'd8235497;
			{FREQ_93K7, 3'd0}: v = 64'd4941297987496;
			{FREQ_93K7, 3'd1}: v = 64'd494129798750;
			{FREQ_93K7, 3'd2}: v = 64'd49412979875;
			{FREQ_93K7, 3'd3}: v = 64'd4941297988;
			{FREQ_93K7, 3'd4}: v = 64'd494129799;
			{FREQ_93K7, 3'd5}: v = 64'd49412980;
			default:           v = 64'd0;
		endcase
		return CMPW'(v);
	endfunction

	// |X| bounds per frequency for C = 5e-4, 5e-5, 5e-6, 3e-7 .. 3e-10, 3e-12 F
	function automatic qval_t cap_bound(input freq_t f, input logic [2:0] i);
		logic [63:0] v;
		v = 64'd0;
		case ({f, i})
			{FREQ_122, 3'd0}:  v = 64'd43748177;
			{FREQ_122, 3'd1}:  v = 64'd437481776;
			{FREQ_122, 3'd2}:  v = 64'd4374817763;
			{FREQ_122, 3'd3}:  v = 64'd72913629394;
			{FREQ_122, 3'd4}:  v = 64'd729136293948;
			{FREQ_122, 3'd5}:  v = 64'd7291362939480;
			{FREQ_122, 3'd6}:  v = 64'd72913629394800;
			{FREQ_122, 3'd7}:  v = 64'd7291362939480000;
			{FREQ_977, 3'd0}:  v = 64'd5468522;
			{FREQ_977, 3'd1}:  v = 64'd54685222;
			{FREQ_977, 3'd2}:  v = 64'd546852220;
			{FREQ_977, 3'd3}:  v = 64'd9114203674;
			{FREQ_977, 3'd4}:  v = 64'd91142036743;
			{FREQ_977, 3'd5}:  v = 64'd911420367435;
			{FREQ_977, 3'd6}:  v = 64'd9114203674350;
			{FREQ_977, 3'd7}:  v = 64'd911420367435000;
			{FREQ_15K6, 3'd0}: v = 64'd341782;
			{FREQ_15K6, 3'd1}: v = 64'd3417826;
			{FREQ_15K6, 3'd2}: v = 64'd34178263;
			{FREQ_15K6, 3'd3}: v = 64'd569637729;
			{FREQ_15K6, 3'd4}: v = 64'd5696377296;
			{FREQ_15K6, 3'd5}: v = 64'd56963772964;
			{FREQ_15K6, 3'd6}: v = 64'd569637729647;
			{FREQ_15K6, 3'd7}: v = 64'd56963772964700;
			{FREQ_93K7, 3'd0}: v = 64'd56963;
			{FREQ_93K7, 3'd1}: v = 64'd569637;
			{FREQ_93K7, 3'd2}: v = 64'd5696377;
			{FREQ_93K7, 3'd3}: v = 64'd94939621;
			{FREQ_93K7, 3'd4}: v = 64'd949396216;
			{FREQ_93K7, 3'd5}: v = 64'd9493962160;
			{FREQ_93K7, 3'd6}: v = 64'd94939621607;
			{FREQ_93K7, 3'd7}: v = 64'd9493962160780;
			default:           v = 64'd0;
		endcase
		return CMPW'(v);
	endfunction

	// 60000, 6000, 500, 26 and 0.4 ohm in Q24
	function automatic qval_t ohm_level(input logic [2:0] i);
		logic [63:0] v;
		v = 64'd0;
		case (i)
			3'd0:    v = 64'd1006632960000;
			3'd1:    v = 64'd100663296000;
			3'd2:    v = 64'd8388608000;
			3'd3:    v = 64'd436207616;
			3'd4:    v = 64'd6710887;
			default: v = 64'd0;
		endcase
		return CMPW'(v);
	endfunction

endpackage

// File: rtl/lcrma_step.sv
// ----------------------------------------------------------------------------
// lcrma_step
// Next-state logic: classification, band compares and range selection for
// one item against the current settings.
// ----------------------------------------------------------------------------
module lcrma_step (
	input  lcrma_pkg::op_t                          op,
	input  logic signed [lcrma_pkg::MEAS_W-1:0]     resistance,
	input  logic signed [lcrma_pkg::MEAS_W-1:0]     reactance,
	input  logic        [lcrma_pkg::IMP_W-1:0]      impedance,
	input  logic                                    auto_en,
	input  lcrma_pkg::state_t                       cur,
	output lcrma_pkg::state_t                       nxt,
	output lcrma_pkg::mask_t                        report
);
	import lcrma_pkg::*;

	typedef struct packed {
		sense_t sense;
		gain_t  gain;
	} sg_t;

	function automatic sg_t pick_level(input logic neg, input qval_t q);
		sg_t s;
		if (neg)                       s = '{SENSE_10R,  GAIN_X34};
		else if (q >= ohm_level(3'd0)) s = '{SENSE_100K, GAIN_X2};
		else if (q >= ohm_level(3'd1)) s = '{SENSE_10K,  GAIN_X2};
		else if (q >= ohm_level(3'd2)) s = '{SENSE_1K,   GAIN_X2};
		else if (q >= ohm_level(3'd3)) s = '{SENSE_100R, GAIN_X13};
		else if (q >= ohm_level(3'd4)) s = '{SENSE_10R,  GAIN_X13};
		else                           s = '{SENSE_10R,  GAIN_X34};
		return s;
	endfunction

	logic              rneg, xneg;
	logic [MEAS_W-1:0] rmag, xmag;
	logic [MEAS_W+4:0] rmag_ext, x25;
	qval_t             rq, xq, zq;
	logic [5:0]        ind_ge;
	logic [7:0]        cap_le;
	sg_t               lvl;
	freq_t             ind_f, cap_f, nf;
	sense_t            ind_s, cap_s;
	gain_t             ind_g, cap_g;
	ptype_t            t;

	assign rneg = resistance[MEAS_W-1];
	assign xneg = reactance[MEAS_W-1];
	assign rmag = rneg ? (~resistance + MEAS_W'(1)) : resistance;
	assign xmag = xneg ? (~reactance + MEAS_W'(1)) : reactance;

	assign rmag_ext = {5'd0, rmag};
	assign x25      = ({5'd0, xmag} << 4) + ({5'd0, xmag} << 3) + {5'd0, xmag};

	assign rq = CMPW'(rmag) << SHIFT_Q;
	assign xq = CMPW'(xmag) << SHIFT_Q;
	assign zq = CMPW'(impedance) << SHIFT_Q;

	// compare |X| against every band bound of the current frequency at once
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			ind_ge[i] = xq >= ind_bound(cur.freq, 3'(i));
		end
		for (int i = 0; i < 8; i++) begin
			cap_le[i] = xq <= cap_bound(cur.freq, 3'(i));
		end
	end

	always_comb begin
		if (ind_ge[0])      {ind_f, ind_s, ind_g} = {FREQ_122,  SENSE_1K,   GAIN_X2};
		else if (ind_ge[1]) {ind_f, ind_s, ind_g} = {FREQ_122,  SENSE_100R, GAIN_X2};
		else if (ind_ge[2]) {ind_f, ind_s, ind_g} = {FREQ_977,  SENSE_100R, GAIN_X2};
		else if (ind_ge[4]) {ind_f, ind_s, ind_g} = {FREQ_15K6, SENSE_10R,  GAIN_X5};
		else if (ind_ge[5]) {ind_f, ind_s, ind_g} = {FREQ_15K6, SENSE_10R,  GAIN_X13};
		else                {ind_f, ind_s, ind_g} = {FREQ_93K7, SENSE_10R,  GAIN_X34};
	end

	always_comb begin
		if (cap_le[0])      {cap_f, cap_s, cap_g} = {FREQ_122,  SENSE_10R,  GAIN_X34};
		else if (cap_le[1]) {cap_f, cap_s, cap_g} = {FREQ_122,  SENSE_10R,  GAIN_X13};
		else if (cap_le[2]) {cap_f, cap_s, cap_g} = {FREQ_122,  SENSE_100R, GAIN_X2};
		else if (cap_le[3]) {cap_f, cap_s, cap_g} = {FREQ_977,  SENSE_100R, GAIN_X2};
		else if (cap_le[4]) {cap_f, cap_s, cap_g} = {FREQ_977,  SENSE_1K,   GAIN_X2};
		else if (cap_le[5]) {cap_f, cap_s, cap_g} = {FREQ_977,  SENSE_10K,  GAIN_X2};
		else if (cap_le[6]) {cap_f, cap_s, cap_g} = {FREQ_15K6, SENSE_1K,   GAIN_X2};
		else if (cap_le[7]) {cap_f, cap_s, cap_g} = {FREQ_93K7, SENSE_10K,  GAIN_X2};
		else                {cap_f, cap_s, cap_g} = {FREQ_93K7, SENSE_100K, GAIN_X2};
	end

	// frequency pick by L or C band for the range-by-impedance operation
	always_comb begin
		if (!xneg) begin
			if (ind_ge[1])      nf = FREQ_122;
			else if (ind_ge[3]) nf = FREQ_977;
			else if (ind_ge[5]) nf = FREQ_15K6;
			else                nf = FREQ_93K7;
		end else begin
			if (cap_le[2])      nf = FREQ_122;
			else if (cap_le[5]) nf = FREQ_977;
			else if (cap_le[6]) nf = FREQ_15K6;
			else                nf = FREQ_93K7;
		end
	end

	always_comb begin
		lvl = pick_level(rneg && (op == OP_CLASSIFY), (op == OP_CLASSIFY) ? rq : zq);
	end

	always_comb begin
		nxt = cur;
		t   = cur.ptype;
		case (op)
			OP_CLASSIFY: begin
				if (auto_en) begin
					if (cur.ptype == PT_UNKNOWN) begin
						if (rmag_ext >= x25) begin
							t = PT_RES;
							nxt.freq = FREQ_977;
							nxt.pending = nxt.pending | PEND_FREQ;
						end else begin
							t = xneg ? PT_CAP : PT_IND;
						end
					end
					nxt.ptype = t;
					case (t)
						PT_RES: begin
							nxt.sense = lvl.sense;
							nxt.gain  = lvl.gain;
							nxt.pending = nxt.pending | PEND_SG;
						end
						PT_IND: begin
							nxt.freq  = ind_f;
							nxt.sense = ind_s;
							nxt.gain  = ind_g;
							nxt.pending = PEND_ALL;
						end
						PT_CAP: begin
							nxt.freq  = cap_f;
							nxt.sense = cap_s;
							nxt.gain  = cap_g;
							nxt.pending = PEND_ALL;
						end
						default: begin
						end
					endcase
				end
			end
			OP_RANGE: begin
				if (auto_en) begin
					nxt.freq = nf;
					nxt.pending = nxt.pending | PEND_FREQ;
				end
				nxt.sense = lvl.sense;
				nxt.gain  = lvl.gain;
				nxt.pending = nxt.pending | PEND_SG;
			end
			OP_APPLY: begin
				if (cur.pending != '0) begin
					nxt.pending = '0;
					nxt.ptype   = PT_UNKNOWN;
				end
			end
			default: begin
			end
		endcase
	end

	// apply reports the mask held before its clear; everything else the new one
	assign report = (op == OP_APPLY) ? cur.pending : nxt.pending;

endmodule

// File: rtl/lcr_meter_autorange_core.sv
// ----------------------------------------------------------------------------
// lcr_meter_autorange_core
// Auto-ranging controller: classifies the part and selects test frequency,
// sense resistor and gain from measured R, X and |Z|.
// ----------------------------------------------------------------------------
// The core takes one item per clock while the result register is free, and
// returns one result per item on m_tvalid from the result register, behind
// the input register. The rate is set by the settings loop: the stage-1 item
// is compared against the threshold tables of the current frequency and the
// new settings land in the state register in the same cycle, so the next
// item sees them at once. The user writes auto_enable over the cfg port only
// while no item is in flight; the core itself does not enforce this.
module lcr_meter_autorange_core (
	input  logic        clk,
	input  logic        arst_n,
	// cfg_data: auto_enable
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	// s_tdata: resistance[39:0], reactance[79:40], impedance[118:80], zero pad
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [119:0] s_tdata,
	// s_tuser: operation[1:0]
	input  logic [1:0]  s_tuser,
	// m_tdata: freq_index[1:0], sense_index[4:2], gain_index[6:5],
	// part_type[8:7], changed_mask[11:9], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata
);
	import lcrma_pkg::*;

	logic                     auto_en_q;
	logic                     valid_s1;
	op_t                      op_s1;
	logic signed [MEAS_W-1:0] r_s1, x_s1;
	logic [IMP_W-1:0]         z_s1;
	state_t                   state_q, state_nxt;
	mask_t                    report;
	logic                     out_valid_q;
	logic [15:0]              out_data_q;
	logic                     out_free, adv_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_en_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			auto_en_q <= cfg_data;
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign adv_s1   = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1 <= s_tuser;
			r_s1  <= s_tdata[MEAS_W-1:0];
			x_s1  <= s_tdata[2*MEAS_W-1:MEAS_W];
			z_s1  <= s_tdata[2*MEAS_W+IMP_W-1:2*MEAS_W];
		end
	end

	lcrma_step u_step (
		.op         (op_s1),
		.resistance (r_s1),
		.reactance  (x_s1),
		.impedance  (z_s1),
		.auto_en    (auto_en_q),
		.cur        (state_q),
		.nxt        (state_nxt),
		.report     (report)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data_q <= {4'd0, report, state_nxt.ptype, state_nxt.gain,
				state_nxt.sense, state_nxt.freq};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef ASSERT_OFF
	a_apply_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && (op_s1 == OP_APPLY) |=> state_q.pending == '0)
		else $error("pending mask not cleared after apply");

	a_classify_types: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && (op_s1 == OP_CLASSIFY) && auto_en_q |=> state_q.ptype != PT_UNKNOWN)
		else $error("part type still unknown after classify");

	a_sense_legal: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.sense <= SENSE_10R)
		else $error("sense resistor index out of range");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> m_tvalid && (m_tdata[8:0] == {state_q.ptype, state_q.gain,
			state_q.sense, state_q.freq}))
		else $error("result does not match the settings register");
`endif

endmodule
